// ===== src/b64_pkg.sv =====
`default_nettype none
package b64_pkg;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam int QueueDepth = 2;

  // One request for the back end: up to four result bytes, shown in order.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte of this request
    logic            data;      // 0 for a bare end mark
    logic            last;      // the final byte closes the message
  } b64_job_t;

  typedef struct packed {
    logic     push;
    b64_job_t job;
  } b64_push_t;

  typedef struct packed {
    logic     avail;
    b64_job_t job;
  } b64_head_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26) begin
      return 8'h41 + w;
    end else if (s < 6'd52) begin
      return 8'h61 + w - 8'd26;
    end else if (s < 6'd62) begin
      return 8'h30 + w - 8'd52;
    end else if (s == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  // Bit 6 set means the character is not in the alphabet.
  function automatic logic [6:0] dec_sextet(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'h00;
    if (ch inside {[8'h41:8'h5A]}) begin
      v = ch - 8'h41;
    end else if (ch inside {[8'h61:8'h7A]}) begin
      v = ch - 8'h61 + 8'd26;
    end else if (ch inside {[8'h30:8'h39]}) begin
      v = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2B) begin
      v = 8'd62;
    end else if (ch == 8'h2F) begin
      v = 8'd63;
    end else begin
      return 7'h40;
    end
    return {1'b0, v[5:0]};
  endfunction

endpackage
`default_nettype wire

// ===== src/b64_if.sv =====
`default_nettype none
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  modport source (output valid, out_byte, out_valid, out_last, input ready);
  modport sink (input valid, out_byte, out_valid, out_last, output ready);
endinterface

interface b64_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface
`default_nettype wire

// ===== src/b64_front.sv =====
`default_nettype none
module b64_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  b64_in_if.sink              in_i,
  b64_cfg_if.sink             cfg_i,
  input  wire logic           q_full_i,
  output b64_pkg::b64_push_t  push_o
);

  logic        mode_q, mode_d;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        stop_q, stop_d;

  logic        accept;
  logic [23:0] gb;
  logic [1:0]  c2;
  logic [6:0]  sx;
  logic        full;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full_i && !cfg_i.valid;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    mode_d      = mode_q;
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    stop_d      = stop_q;
    push_o      = '0;
    gb          = bits_q;
    c2          = cnt_q;
    sx          = b64_pkg::dec_sextet(in_i.in_byte);
    full        = 1'b0;
    if (cfg_i.valid) begin
      mode_d = cfg_i.mode;
      bits_d = '0;
      cnt_d  = '0;
      stop_d = 1'b0;
    end else if (accept) begin
      if (mode_q == b64_pkg::ModeEncode) begin
        case (cnt_q)
          2'd0:    gb = {in_i.in_byte, bits_q[15:0]};
          2'd1:    gb = {bits_q[23:16], in_i.in_byte, bits_q[7:0]};
          default: gb = {bits_q[23:8], in_i.in_byte};
        endcase
        push_o.job.bytes[0] = b64_pkg::enc_char(gb[23:18]);
        push_o.job.bytes[1] = b64_pkg::enc_char(gb[17:12]);
        push_o.job.bytes[2] = b64_pkg::enc_char(gb[11:6]);
        push_o.job.bytes[3] = b64_pkg::enc_char(gb[5:0]);
        push_o.job.last_idx = 2'd3;
        push_o.job.data     = 1'b1;
        if (cnt_q == 2'd2) begin
          push_o.push = 1'b1;
          bits_d      = '0;
          cnt_d       = '0;
        end else if (in_i.in_last) begin
          // A short final group is padded out to four characters.
          push_o.push = 1'b1;
          if (cnt_q == 2'd0) begin
            push_o.job.bytes[2] = b64_pkg::PadChar;
          end
          push_o.job.bytes[3] = b64_pkg::PadChar;
        end else begin
          bits_d = gb;
          cnt_d  = cnt_q + 2'd1;
        end
      end else begin
        if (!stop_q) begin
          if (!sx[6]) begin
            case (cnt_q)
              2'd0:    gb = {sx[5:0], bits_q[17:0]};
              2'd1:    gb = {bits_q[23:18], sx[5:0], bits_q[11:0]};
              2'd2:    gb = {bits_q[23:12], sx[5:0], bits_q[5:0]};
              default: gb = {bits_q[23:6], sx[5:0]};
            endcase
            c2 = cnt_q + 2'd1;
            full = (cnt_q == 2'd3);
          end else begin
            stop_d = 1'b1;
          end
        end
        push_o.job.bytes[0] = gb[23:16];
        push_o.job.bytes[1] = gb[15:8];
        push_o.job.bytes[2] = gb[7:0];
        push_o.job.bytes[3] = 8'h00;
        push_o.job.data     = 1'b1;
        if (full) begin
          push_o.push         = 1'b1;
          push_o.job.last_idx = 2'd2;
          gb = '0;
        end else if (in_i.in_last) begin
          push_o.push = 1'b1;
          if (c2 >= 2'd2) begin
            push_o.job.last_idx = c2 - 2'd2;
          end else begin
            // Nothing left to decode: send only the end mark.
            push_o.job.bytes    = '0;
            push_o.job.last_idx = 2'd0;
            push_o.job.data     = 1'b0;
          end
        end
        bits_d = gb;
        cnt_d  = c2;
      end
      if (in_i.in_last) begin
        push_o.job.last = 1'b1;
        bits_d = '0;
        cnt_d  = '0;
        stop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= b64_pkg::ModeEncode;
      bits_q <= '0;
      cnt_q  <= '0;
      stop_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/b64_queue.sv =====
`default_nettype none
module b64_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire b64_pkg::b64_push_t  push_i,
  input  wire logic                pop_i,
  output logic                     full_o,
  output b64_pkg::b64_head_t       head_o
);

  b64_pkg::b64_job_t mem_q [b64_pkg::QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'(b64_pkg::QueueDepth));
  assign head_o.avail = (cnt_q != 2'd0);
  assign head_o.job   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({push_i.push, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/b64_back.sv =====
`default_nettype none
module b64_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire b64_pkg::b64_head_t  head_i,
  output logic                     pop_o,
  b64_out_if.source                out_o
);

  b64_pkg::b64_job_t job_q, job_d;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       done;

  assign out_o.valid     = busy_q;
  assign out_o.out_byte  = job_q.bytes[idx_q];
  assign out_o.out_valid = job_q.data;
  assign out_o.out_last  = job_q.last && (idx_q == job_q.last_idx);

  // The request in hand finishes when its final byte is taken.
  assign done  = busy_q && out_o.ready && (idx_q == job_q.last_idx);
  assign pop_o = head_i.avail && (!busy_q || done);

  always_comb begin
    job_d  = job_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      job_d  = head_i.job;
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && out_o.ready) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/base64_stream_codec.sv =====
// Streaming base64 codec with the standard alphabet. A write to the configuration
// channel selects encode (mode 0) or decode (mode 1) and drops any message in
// progress; write it only while the block is idle. The input side takes one item
// per cycle as long as the two-entry request queue has room and no configuration
// write is pending; the output side sends one result per cycle from a request
// register while the receiver is ready. Encoding three bytes thus yields four
// results and decoding four characters three, so the output port sets the
// sustained rate when encoding and the input port when decoding. A last item
// that decodes to nothing yields one result with out_valid low and out_last high.
`default_nettype none
module base64_stream_codec (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b64_in_if.sink     in_i,
  b64_cfg_if.sink    cfg_i,
  b64_out_if.source  out_o
);

  b64_pkg::b64_push_t push;
  b64_pkg::b64_head_t head;
  logic               q_full;
  logic               pop;

  b64_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  b64_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  b64_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ===== src/b64_checker.sv =====
`default_nettype none
module b64_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_i,
  input wire logic       out_req_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_valid_i,
  input wire logic       out_last_i
);

  // A result without data only ever closes a message.
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req_i && !out_valid_i |-> out_last_i)
    else $error("bare result without end mark");

  a_bare_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req_i && !out_valid_i |-> out_byte_i == 8'h00)
    else $error("bare result carries a nonzero byte");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req_i && !out_ready_i |=> out_req_i && $stable(out_byte_i)
      && $stable(out_valid_i) && $stable(out_last_i))
    else $error("stalled result changed");

endmodule

bind base64_stream_codec b64_checker u_b64_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .out_req_i   (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_valid_i (out_o.out_valid),
  .out_last_i  (out_o.out_last)
);
`default_nettype wire

// ===== verif/base64_stream_codec_tb.sv =====
module base64_stream_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int NotInAlphabet = 64;
  localparam int IdlePercent = 12;
  localparam int HoldCycles = 80;
  localparam int QuietCycles = 16;
  localparam int CycleLimit = 200000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0] ch;
    logic       valid;
    logic       last;
  } codec_out_t;

  // Tracks the codec state and the results still owed by the block.
  class codec_ledger;
    logic         mode;
    logic [23:0]  bits;
    int unsigned  count;
    bit           stopped;
    codec_out_t   owed[$];
    int           errors;
    int           checked;

    function new();
      mode = b64_pkg::ModeEncode;
      clear_group();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_group();
      bits = '0;
      count = 0;
      stopped = 1'b0;
    endfunction

    function void write_mode(logic m);
      mode = m;
      clear_group();
    endfunction

    function int sextet_of(logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return NotInAlphabet;
    endfunction

    function logic [7:0] char_of(int unsigned pos);
      logic [5:0] s;
      s = 6'(bits >> (18 - 6 * pos));
      return Alphabet[s];
    endfunction

    function void note_item(logic [7:0] b, logic is_last);
      codec_out_t made[$];
      codec_out_t r;
      int         sx;
      r.valid = 1'b1;
      r.last = 1'b0;
      if (mode == b64_pkg::ModeEncode) begin
        bits = bits | (24'(b) << (16 - 8 * count));
        count++;
        if (count == 3) begin
          for (int i = 0; i < 4; i++) begin
            r.ch = char_of(i);
            made.push_back(r);
          end
          bits = '0;
          count = 0;
        end
        if (is_last && count != 0) begin
          for (int i = 0; i < 4; i++) begin
            r.ch = (i <= count) ? char_of(i) : b64_pkg::PadChar;
            made.push_back(r);
          end
        end
      end else begin
        if (!stopped) begin
          sx = sextet_of(b);
          if (sx < NotInAlphabet) begin
            bits = bits | (24'(sx) << (18 - 6 * count));
            count = (count + 1) % 4;
            if (count == 0) begin
              for (int i = 0; i < 3; i++) begin
                r.ch = 8'(bits >> (16 - 8 * i));
                made.push_back(r);
              end
              bits = '0;
            end
          end else begin
            stopped = 1'b1;
          end
        end
        if (is_last && count >= 2) begin
          for (int i = 0; i + 1 < count; i++) begin
            r.ch = 8'(bits >> (16 - 8 * i));
            made.push_back(r);
          end
        end
        // A closing item that decodes to nothing still owes a bare end mark.
        if (is_last && made.size() == 0) begin
          r.ch = 8'h00;
          r.valid = 1'b0;
          made.push_back(r);
        end
      end
      if (is_last) begin
        made[made.size() - 1].last = 1'b1;
        clear_group();
      end
      foreach (made[i]) owed.push_back(made[i]);
    endfunction

    function void check_out(logic [7:0] ch, logic v, logic l);
      codec_out_t e;
      checked++;
      if (owed.size() == 0) begin
        $error("result with nothing owed: out_byte %h out_valid %b out_last %b", ch, v, l);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (ch !== e.ch) begin
        $error("out_byte: expected %h, actual %h", e.ch, ch);
        errors++;
      end
      if (v !== e.valid) begin
        $error("out_valid: expected %b, actual %b", e.valid, v);
        errors++;
      end
      if (l !== e.last) begin
        $error("out_last: expected %b, actual %b", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   hold_requests;
  int   items_sent;
  int   mode_writes;
  int   cycles;

  b64_in_if  in_bus ();
  b64_out_if out_bus ();
  b64_cfg_if cfg_bus ();

  codec_ledger ledger = new();

  base64_stream_codec uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        ledger.write_mode(cfg_bus.mode);
        mode_writes++;
      end
      if (in_bus.valid && in_bus.ready) begin
        ledger.note_item(in_bus.in_byte, in_bus.in_last);
      end
      if (out_bus.valid && out_bus.ready) begin
        ledger.check_out(out_bus.out_byte, out_bus.out_valid, out_bus.out_last);
      end
    end
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int held;
    int served;
    held = 0;
    served = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_requests && held == 0) begin
        held = HoldCycles;
        served++;
      end
      if (held > 0) begin
        held--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic [7:0] b, logic is_last);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_byte <= b;
    in_bus.in_last <= is_last;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(byte_q_t msg);
    foreach (msg[i]) send_item(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_text(string t);
    byte_q_t msg;
    for (int i = 0; i < t.len(); i++) msg.push_back(t[i]);
    send_message(msg);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (ledger.owed.size() != 0) @(negedge clk);
    repeat (QuietCycles) @(negedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_bus.valid <= 1'b1;
    cfg_bus.mode <= m;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_encode(int n_items);
    byte_q_t msg;
    int      stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      msg.delete();
      repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom_range(0, 255)));
      send_message(msg);
    end
  endtask

  // Mostly well-formed text with padding; some messages carry junk characters.
  task automatic random_decode(int n_items);
    byte_q_t msg;
    int      tail;
    int      stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      msg.delete();
      repeat ($urandom_range(0, 3) * 4) msg.push_back(Alphabet[$urandom_range(0, 63)]);
      tail = $urandom_range(0, 3);
      repeat (tail) msg.push_back(Alphabet[$urandom_range(0, 63)]);
      if (tail >= 2 && $urandom_range(0, 1) == 1) begin
        repeat (4 - tail) msg.push_back(b64_pkg::PadChar);
      end
      if (msg.size() == 0) msg.push_back(Alphabet[$urandom_range(0, 63)]);
      if ($urandom_range(0, 99) < 15) begin
        msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
      end
      send_message(msg);
    end
  endtask

  initial begin
    steady = 1'b0;
    hold_requests = 0;
    items_sent = 0;
    mode_writes = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.in_byte = 8'h00;
    in_bus.in_last = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.mode = b64_pkg::ModeEncode;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Encode straight out of reset: one, two and three byte groups, then a
    // full group followed by a one byte tail.
    send_message('{8'h00});
    send_message('{8'hFF, 8'hFF});
    send_message('{8'hFB, 8'hEF, 8'hBE});
    send_message('{8'h01, 8'h02, 8'h80, 8'h7F});
    wait_idle();

    // Decode: every alphabet range, padding with junk after it, a lone
    // sextet, and a closing character outside the alphabet.
    write_mode(b64_pkg::ModeDecode);
    send_text("+/09azAZ");
    send_text("QQ=x");
    send_text("Q");
    send_message('{8'hFF});
    wait_idle();

    write_mode(b64_pkg::ModeEncode);
    random_encode(80);
    steady = 1'b1;
    random_encode(35);
    steady = 1'b0;
    wait_idle();

    write_mode(b64_pkg::ModeDecode);
    hold_requests++;
    random_decode(90);
    wait_idle();

    // Leave a decode message half done; the mode write must drop it.
    send_item("T", 1'b0);
    send_item("W", 1'b0);
    wait_idle();
    write_mode(b64_pkg::ModeEncode);
    send_item(8'hA5, 1'b0);
    wait_idle();
    write_mode(b64_pkg::ModeEncode);
    hold_requests++;
    random_encode(30);
    wait_idle();

    write_mode(b64_pkg::ModeDecode);
    random_decode(25);
    wait_idle();

    if (ledger.owed.size() != 0) begin
      $error("%0d results never arrived", ledger.owed.size());
      ledger.errors++;
    end
    $display("Sent %0d items in encode and decode messages across %0d mode writes.",
             items_sent, mode_writes);
    $display("Checked %0d results over %0d cycles, with %0d mismatches.",
             ledger.checked, cycles, ledger.errors);
    if (ledger.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
